@@ src/hyperelastic_stress_hessian_2d_core_assert.svh @@
// ----------------------------------------------------------------------------
// Hessian core assertion macros
// Shared shorthands for the concurrent checks of the hessian core.
// ----------------------------------------------------------------------------
`ifndef HYPERELASTIC_STRESS_HESSIAN_2D_CORE_ASSERT_SVH
`define HYPERELASTIC_STRESS_HESSIAN_2D_CORE_ASSERT_SVH

// Check on every edge outside reset
`define HSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every edge, reset included
`define HSH_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/hsh_pkg.sv @@
// ----------------------------------------------------------------------------
// Hessian core package
// Widths, register codes, pair indexing and saturation helpers.
// ----------------------------------------------------------------------------
package hsh_pkg;

  localparam int unsigned FW        = 32;   // gradient entry width
  localparam int unsigned OW        = 48;   // result value width
  localparam int unsigned CfgW      = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned RowW      = 2;
  localparam int unsigned NumRows   = 4;
  localparam int unsigned NumPairs  = 10;
  localparam int unsigned ChunkW    = 32;   // partial product slice
  localparam int unsigned ClampW    = 62;   // holds +/- 2^60
  localparam int unsigned MulLat    = 3;
  localparam int unsigned InDataW   = 4 * FW;
  localparam int unsigned OutDataW  = 6 * OW;
  localparam int unsigned OutUserW  = RowW + 1;

  localparam logic signed [63:0] ClampLim = 64'sd1 <<< 60;
  localparam logic signed [63:0] Max48    = (64'sd1 <<< 47) - 64'sd1;
  localparam logic signed [63:0] Min48    = -(64'sd1 <<< 47);

  localparam logic [CfgW-1:0] LambdaRst = 32'd65536;
  localparam logic [CfgW-1:0] MuRst     = 32'd65536;
  localparam logic [CfgW-1:0] BetaRst   = 32'd16384;
  localparam logic [CfgW-1:0] AlphaRst  = 32'd65536;

  localparam logic signed [49:0] ThreeQ16 = 50'sd196608;
  localparam logic signed [61:0] NineQ16  = 62'sd589824;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LAMBDA,
    CFG_MU,
    CFG_BETA,
    CFG_ALPHA
  } cfg_idx_e;

  typedef logic signed [ClampW-1:0] clamp_t;

  // Scaled, clamped product with its clamp flag
  typedef struct packed {
    logic   sat;
    clamp_t val;
  } mul_res_t;

  // Slot of the symmetric pair (a, b) among the ten distinct entries
  function automatic int unsigned pair_idx(int unsigned a, int unsigned b);
    int unsigned lo;
    int unsigned hi;
    int unsigned base;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    priority if (lo == 0) base = 0;
    else if (lo == 1)     base = 4;
    else if (lo == 2)     base = 7;
    else                  base = 9;
    return base + hi - lo;
  endfunction

  // Rows whose cofactor entry carries a minus sign
  function automatic logic row_neg(int unsigned r);
    return (r == 1) || (r == 2);
  endfunction

  // Saturate to the result width; top bit flags a clamp
  function automatic logic [OW:0] sat48(logic signed [63:0] v);
    logic [OW:0] r;
    if (v > Max48) begin
      r = {1'b1, Max48[OW-1:0]};
    end else if (v < Min48) begin
      r = {1'b1, Min48[OW-1:0]};
    end else begin
      r = {1'b0, v[OW-1:0]};
    end
    return r;
  endfunction

endpackage

@@ src/hsh_dly.sv @@
// ----------------------------------------------------------------------------
// Hessian core delay line
// Enabled shift register that keeps side data aligned with the multipliers.
// ----------------------------------------------------------------------------
module hsh_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [N];

  // Advance all taps together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[N-1];

endmodule

@@ src/hsh_mulq.sv @@
// ----------------------------------------------------------------------------
// Hessian core scaled multiplier
// Exact signed product from 33x33 partial products, floor shift and clamp
// to +/- 2^60, three register stages.
// ----------------------------------------------------------------------------
module hsh_mulq #(
  parameter int unsigned AW = 33,
  parameter int unsigned BW = 33,
  parameter int unsigned SH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  output hsh_pkg::mul_res_t        res_o
);
  import hsh_pkg::*;

  localparam int unsigned NA  = (AW + ChunkW - 1) / ChunkW;
  localparam int unsigned NB  = (BW + ChunkW - 1) / ChunkW;
  localparam int unsigned XA  = NA * ChunkW;
  localparam int unsigned XB  = NB * ChunkW;
  localparam int unsigned PW  = AW + BW;
  localparam int unsigned PPW = 2 * (ChunkW + 1);
  localparam logic signed [PW-1:0] LimP = PW'(ClampLim);

  logic signed [XA-1:0]     a_ext;
  logic signed [XB-1:0]     b_ext;
  logic signed [ChunkW:0]   ca [NA];
  logic signed [ChunkW:0]   cb [NB];
  logic signed [PPW-1:0]    pp_q [NA][NB];
  logic signed [PW-1:0]     sum_d, sum_q;
  logic signed [PW-1:0]     shr;
  mul_res_t                 res_d, res_q;

  assign a_ext = XA'(a_i);
  assign b_ext = XB'(b_i);

  // Slice operands: lower slices unsigned, top slice carries the sign
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      ca[i] = (i == NA - 1) ? {a_ext[ChunkW*i+ChunkW-1], a_ext[ChunkW*i +: ChunkW]}
                            : {1'b0, a_ext[ChunkW*i +: ChunkW]};
    end
    for (int j = 0; j < NB; j++) begin
      cb[j] = (j == NB - 1) ? {b_ext[ChunkW*j+ChunkW-1], b_ext[ChunkW*j +: ChunkW]}
                            : {1'b0, b_ext[ChunkW*j +: ChunkW]};
    end
  end

  // Stage 1: partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= ca[i] * cb[j];
        end
      end
    end
  end

  // Stage 2: weighted sum of partial products
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_d = sum_d + (PW'(pp_q[i][j]) <<< (ChunkW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  // Stage 3: floor scale and clamp
  always_comb begin
    shr       = sum_q >>> SH;
    res_d.sat = 1'b0;
    res_d.val = ClampW'(shr);
    if (shr > LimP) begin
      res_d.sat = 1'b1;
      res_d.val = ClampW'(LimP);
    end else if (shr < -LimP) begin
      res_d.sat = 1'b1;
      res_d.val = ClampW'(-LimP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ src/hyperelastic_stress_hessian_2d_core.sv @@
// ----------------------------------------------------------------------------
// Hyperelastic stress hessian core, 2D
// Per gradient: four result rows of the stress derivative, stress and energy.
// ----------------------------------------------------------------------------
// Each input item is one 2x2 deformation gradient in Q16.16, column-major.
// The core returns four result items, rows 0 to 3 in order with tlast on
// row 3; each carries one row of the 4x4 stress derivative, the matching
// first Piola-Kirchhoff stress entry and the strain energy, all Q32.16.
// The single result channel sends one row per cycle while the sink is ready;
// the core takes a new gradient only when its output stage is empty or hands
// off the last row of its item. The twelve pipeline stages stall as a whole
// while the output stage still holds rows. Intermediate products clamp at
// +/- 2^60 and results saturate to 48 bits; either raises the saturated flag
// (tuser bit 2) of the affected row. Write the material registers only while
// the core is empty.
module hyperelastic_stress_hessian_2d_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [hsh_pkg::InDataW-1:0]       s_axis_tdata,   // f_00, f_10, f_01, f_11
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [hsh_pkg::OutDataW-1:0]      m_axis_tdata,   // hess_c0..c3, stress, energy
  output logic [hsh_pkg::OutUserW-1:0]      m_axis_tuser,   // row_index, saturated
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [hsh_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [hsh_pkg::CfgW-1:0]          cfg_wdata_i
);
  import hsh_pkg::*;

  localparam int unsigned NStg = 12;
  localparam int unsigned PW64 = 64;
  localparam int unsigned HxyW = ClampW + 1;

  typedef struct packed {
    logic signed [62:0] s;
    clamp_t             lj;
    clamp_t             t1;
    logic               csat;
  } shr_t;

  logic [CfgW-1:0] lambda_q, mu_q, beta_q, alpha_q;
  logic [NStg-1:0] vld_q;
  logic            adv, out_pop, out_done;
  logic [RowW-1:0] row_q;

  // Material registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= LambdaRst;
      mu_q     <= MuRst;
      beta_q   <= BetaRst;
      alpha_q  <= AlphaRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LAMBDA: lambda_q <= cfg_wdata_i;
        CFG_MU:     mu_q     <= cfg_wdata_i;
        CFG_BETA:   beta_q   <= cfg_wdata_i;
        CFG_ALPHA:  alpha_q  <= cfg_wdata_i;
      endcase
    end
  end

  // Pipeline moves when the output stage is empty or hands off its last row
  assign out_pop       = m_axis_tvalid && m_axis_tready;
  assign out_done      = out_pop && (row_q == RowW'(NumRows - 1));
  assign adv           = !vld_q[NStg-1] || out_done;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid};
    end
  end

  // ---------------- S0: capture gradient
  logic [InDataW-1:0] f_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_q <= s_axis_tdata;
    end
  end

  // ---------------- S1: the ten distinct entry products
  logic [NumPairs-1:0][PW64-1:0] p_q, p2;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < NumRows; a++) begin
        for (int b = a; b < NumRows; b++) begin
          p_q[pair_idx(a, b)] <= $signed(f_q[FW*a +: FW]) * $signed(f_q[FW*b +: FW]);
        end
      end
    end
  end

  // ---------------- S2: determinant and trace of F^T F
  logic signed [63:0] det;
  logic [64:0]        sq_sum;
  logic signed [47:0] j16_q;
  logic [48:0]        ic_q;

  always_comb begin
    det    = $signed(p_q[pair_idx(0, 3)]) - $signed(p_q[pair_idx(1, 2)]);
    sq_sum = 65'(p_q[pair_idx(0, 0)]) + 65'(p_q[pair_idx(1, 1)])
           + 65'(p_q[pair_idx(2, 2)]) + 65'(p_q[pair_idx(3, 3)]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      j16_q <= det[63:16];
      ic_q  <= sq_sum[64:16];
    end
  end

  hsh_dly #(.W(NumPairs * PW64), .N(1)) u_dly_p (
    .clk_i, .en_i(adv), .d_i(p_q), .q_o(p2)
  );

  // ---------------- S3: offsets and signed cofactor products
  logic signed [48:0]            dja_q;
  logic [48:0]                   ic3_q;
  logic signed [49:0]            icm3_q;
  logic [NumPairs-1:0][PW64-1:0] gp_q, hp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dja_q  <= $signed({j16_q[47], j16_q}) - $signed({17'b0, alpha_q});
      ic3_q  <= ic_q;
      icm3_q <= $signed({1'b0, ic_q}) - ThreeQ16;
      for (int r = 0; r < NumRows; r++) begin
        for (int c = r; c < NumRows; c++) begin
          hp_q[pair_idx(r, c)] <= p2[pair_idx(r, c)];
          gp_q[pair_idx(r, c)] <= (row_neg(r) ^ row_neg(c))
            ? -p2[pair_idx(NumRows - 1 - r, NumRows - 1 - c)]
            :  p2[pair_idx(NumRows - 1 - r, NumRows - 1 - c)];
        end
      end
    end
  end

  // ---------------- S4..S6: first multiplier rank
  mul_res_t bic_r, lj_r, t1_r, q_r, d2_r;
  mul_res_t hx_r [NumPairs];
  mul_res_t hy_r [NumPairs];

  hsh_mulq #(.AW(33), .BW(50), .SH(16)) u_mul_bic (
    .clk_i, .en_i(adv), .a_i($signed({1'b0, beta_q})), .b_i($signed({1'b0, ic3_q})),
    .res_o(bic_r)
  );
  hsh_mulq #(.AW(33), .BW(49), .SH(16)) u_mul_lj (
    .clk_i, .en_i(adv), .a_i($signed({1'b0, lambda_q})), .b_i(dja_q), .res_o(lj_r)
  );
  hsh_mulq #(.AW(33), .BW(50), .SH(17)) u_mul_t1 (
    .clk_i, .en_i(adv), .a_i($signed({1'b0, mu_q})), .b_i(icm3_q), .res_o(t1_r)
  );
  hsh_mulq #(.AW(50), .BW(50), .SH(16)) u_mul_q (
    .clk_i, .en_i(adv), .a_i($signed({1'b0, ic3_q})), .b_i($signed({1'b0, ic3_q})),
    .res_o(q_r)
  );
  hsh_mulq #(.AW(49), .BW(49), .SH(16)) u_mul_d2 (
    .clk_i, .en_i(adv), .a_i(dja_q), .b_i(dja_q), .res_o(d2_r)
  );

  for (genvar k = 0; k < NumPairs; k++) begin : g_pair_mul
    hsh_mulq #(.AW(33), .BW(64), .SH(32)) u_mul_hx (
      .clk_i, .en_i(adv), .a_i($signed({1'b0, lambda_q})), .b_i($signed(gp_q[k])),
      .res_o(hx_r[k])
    );
    hsh_mulq #(.AW(33), .BW(64), .SH(31)) u_mul_hy (
      .clk_i, .en_i(adv), .a_i($signed({1'b0, beta_q})), .b_i($signed(hp_q[k])),
      .res_o(hy_r[k])
    );
  end

  // ---------------- S7: shared scalars and hessian partial sums
  shr_t                          shr_q, shr_dl;
  logic signed [61:0]            qm9_q;
  clamp_t                        d2_q;
  logic [NumPairs-1:0][HxyW-1:0] hxy_q, hxy_dl;
  logic [NumPairs-1:0]           hsat_q, hsat_dl;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      shr_q.s    <= $signed({31'b0, mu_q}) + 63'(bic_r.val);
      shr_q.lj   <= lj_r.val;
      shr_q.t1   <= t1_r.val;
      shr_q.csat <= bic_r.sat | lj_r.sat | t1_r.sat | q_r.sat | d2_r.sat;
      qm9_q      <= q_r.val - NineQ16;
      d2_q       <= d2_r.val;
      for (int k = 0; k < NumPairs; k++) begin
        hxy_q[k]  <= HxyW'(hx_r[k].val) + HxyW'(hy_r[k].val);
        hsat_q[k] <= hx_r[k].sat | hy_r[k].sat;
      end
    end
  end

  // Gradient rejoins here for the stress products
  logic [InDataW-1:0] f7;
  hsh_dly #(.W(InDataW), .N(7)) u_dly_f (
    .clk_i, .en_i(adv), .d_i(f_q), .q_o(f7)
  );

  // ---------------- S8..S10: second multiplier rank
  mul_res_t           t2_r, t3_r;
  mul_res_t           ps_r [NumRows];
  mul_res_t           pl_r [NumRows];
  logic signed [FW:0] g_s  [NumRows];

  hsh_mulq #(.AW(33), .BW(62), .SH(18)) u_mul_t2 (
    .clk_i, .en_i(adv), .a_i($signed({1'b0, beta_q})), .b_i(qm9_q), .res_o(t2_r)
  );
  hsh_mulq #(.AW(33), .BW(62), .SH(17)) u_mul_t3 (
    .clk_i, .en_i(adv), .a_i($signed({1'b0, lambda_q})), .b_i(d2_q), .res_o(t3_r)
  );

  for (genvar r = 0; r < NumRows; r++) begin : g_row_mul
    localparam int unsigned Src = NumRows - 1 - r;
    assign g_s[r] = row_neg(r)
      ? -$signed({f7[FW*Src+FW-1], f7[FW*Src +: FW]})
      :  $signed({f7[FW*Src+FW-1], f7[FW*Src +: FW]});

    hsh_mulq #(.AW(63), .BW(FW), .SH(16)) u_mul_ps (
      .clk_i, .en_i(adv), .a_i(shr_q.s), .b_i($signed(f7[FW*r +: FW])), .res_o(ps_r[r])
    );
    hsh_mulq #(.AW(ClampW), .BW(FW + 1), .SH(16)) u_mul_pl (
      .clk_i, .en_i(adv), .a_i(shr_q.lj), .b_i(g_s[r]), .res_o(pl_r[r])
    );
  end

  hsh_dly #(.W($bits(shr_t)), .N(MulLat)) u_dly_shr (
    .clk_i, .en_i(adv), .d_i(shr_q), .q_o(shr_dl)
  );
  hsh_dly #(.W(NumPairs * HxyW), .N(MulLat)) u_dly_hxy (
    .clk_i, .en_i(adv), .d_i(hxy_q), .q_o(hxy_dl)
  );
  hsh_dly #(.W(NumPairs), .N(MulLat)) u_dly_hsat (
    .clk_i, .en_i(adv), .d_i(hsat_q), .q_o(hsat_dl)
  );

  // ---------------- S11: final sums, saturation, output stage
  logic signed [63:0] e_sum;
  logic [OW:0]        e_res;
  logic               csat;
  logic signed [63:0] h_sum [NumPairs];
  logic [OW:0]        h_res [NumPairs];
  logic signed [63:0] p_sum [NumRows];
  logic [OW:0]        p_res [NumRows];
  logic               rsat_d [NumRows];

  always_comb begin
    e_sum = 64'(shr_dl.t1) + 64'(t2_r.val) + 64'(t3_r.val);
    e_res = sat48(e_sum);
    csat  = shr_dl.csat | t2_r.sat | t3_r.sat | e_res[OW];

    for (int r = 0; r < NumRows; r++) begin
      for (int c = r; c < NumRows; c++) begin
        h_sum[pair_idx(r, c)] = 64'($signed(hxy_dl[pair_idx(r, c)]));
        if (r == c) begin
          h_sum[pair_idx(r, c)] = h_sum[pair_idx(r, c)] + 64'(shr_dl.s);
        end else if (r == 0 && c == 3) begin
          h_sum[pair_idx(r, c)] = h_sum[pair_idx(r, c)] + 64'(shr_dl.lj);
        end else if (r == 1 && c == 2) begin
          h_sum[pair_idx(r, c)] = h_sum[pair_idx(r, c)] - 64'(shr_dl.lj);
        end
        h_res[pair_idx(r, c)] = sat48(h_sum[pair_idx(r, c)]);
      end
    end

    for (int r = 0; r < NumRows; r++) begin
      p_sum[r]  = 64'(ps_r[r].val) + 64'(pl_r[r].val);
      p_res[r]  = sat48(p_sum[r]);
      rsat_d[r] = csat | ps_r[r].sat | pl_r[r].sat | p_res[r][OW];
      for (int c = 0; c < NumRows; c++) begin
        rsat_d[r] = rsat_d[r] | hsat_dl[pair_idx(r, c)] | h_res[pair_idx(r, c)][OW];
      end
    end
  end

  logic [OW-1:0] h_q [NumPairs];
  logic [OW-1:0] pk_q [NumRows];
  logic [OW-1:0] energy_q;
  logic          rsat_q [NumRows];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      energy_q <= e_res[OW-1:0];
      for (int k = 0; k < NumPairs; k++) begin
        h_q[k] <= h_res[k][OW-1:0];
      end
      for (int r = 0; r < NumRows; r++) begin
        pk_q[r]   <= p_res[r][OW-1:0];
        rsat_q[r] <= rsat_d[r];
      end
    end
  end

  // Step through the four rows of the held item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (out_pop) begin
      row_q <= row_q + 1'b1;
    end
  end

  logic [OW-1:0] hcol [NumRows];
  always_comb begin
    for (int c = 0; c < NumRows; c++) begin
      hcol[c] = '0;
      for (int r = 0; r < NumRows; r++) begin
        if (row_q == RowW'(r)) begin
          hcol[c] = h_q[pair_idx(r, c)];
        end
      end
    end
  end

  assign m_axis_tvalid = vld_q[NStg-1];
  assign m_axis_tdata  = {energy_q, pk_q[row_q], hcol[3], hcol[2], hcol[1], hcol[0]};
  assign m_axis_tuser  = {rsat_q[row_q], row_q};
  assign m_axis_tlast  = (row_q == RowW'(NumRows - 1));

endmodule

@@ src/hsh_chk.sv @@
// ----------------------------------------------------------------------------
// Hessian core port checker
// Watches the stream ports of the core over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "hyperelastic_stress_hessian_2d_core_assert.svh"

module hsh_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [hsh_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [hsh_pkg::OutUserW-1:0]  m_axis_tuser,
  input logic                          m_axis_tlast
);
  import hsh_pkg::*;

  // Stalled result holds its payload
  `HSH_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Rows of one item follow in order without a gap in valid
  `HSH_ASSERT(a_row_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && (m_axis_tuser[RowW-1:0] == RowW'($past(m_axis_tuser[RowW-1:0]) + 1'b1)), "row index skipped")

  // Energy is shared by all rows of an item
  `HSH_ASSERT(a_energy_hold, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> $stable(m_axis_tdata[OutDataW-1 -: OW]), "energy changed within item")

  // No new gradient while the output stage is stalled
  `HSH_ASSERT(a_in_block, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken during output stall")

  // Nothing leaves during reset
  `HSH_ASSERT_RST(a_rst_quiet, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind hyperelastic_stress_hessian_2d_core hsh_chk u_hsh_chk (.*);
